FILE: hw/rtl/mlpbp_pkg.sv
// Shared constants, codes and types for the MLP backpropagation weight update block.
package mlpbp_pkg;

   // Sizing of the stores
   localparam int MAX_LAYERS = 4;
   localparam int MAX_NODES  = 64;
   localparam int MAX_FANIN  = 128;
   localparam int VEC_DEPTH  = 512;
   localparam int REG_LAYERS = 4;
   localparam int NEURONS    = MAX_LAYERS * MAX_NODES;

   // Port field widths
   localparam int OP_W       = 3;
   localparam int NEUR_FLD_W = 8;
   localparam int POS_W      = 9;
   localparam int VAL_W      = 32;
   localparam int KIND_W     = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 17;
   localparam int LCNT_W     = 3;
   localparam int ICNT_W     = 7;
   localparam int NODE_W     = 7;
   localparam int RATE_W     = 17;

   // Internal widths
   localparam int LAYER_W = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
   localparam int CNT_W   = $clog2(MAX_NODES + 1);
   localparam int NIDX_W  = $clog2(MAX_NODES);
   localparam int NEUR_W  = $clog2(NEURONS);
   localparam int FAN_W   = $clog2(MAX_FANIN);
   localparam int FANC_W  = $clog2(MAX_FANIN + 1);
   localparam int VEC_W   = $clog2(VEC_DEPTH);
   localparam int WADDR_W = NEUR_W + FAN_W;
   localparam int PROD_W  = 2 * VAL_W;
   localparam int FRAC_W  = 16;
   localparam int TERM_W  = PROD_W - FRAC_W;
   localparam int BSUM_W  = TERM_W + NIDX_W;

   // Input operations
   localparam logic [OP_W-1:0] OP_LOAD_W  = 3'd0;
   localparam logic [OP_W-1:0] OP_LOAD_A  = 3'd1;
   localparam logic [OP_W-1:0] OP_LOAD_D  = 3'd2;
   localparam logic [OP_W-1:0] OP_LOAD_E  = 3'd3;
   localparam logic [OP_W-1:0] OP_RUN     = 3'd4;
   localparam logic [OP_W-1:0] OP_READ_W  = 3'd5;
   localparam logic [OP_W-1:0] OP_READ_D  = 3'd6;

   // Result kinds
   localparam logic [KIND_W-1:0] KIND_WEIGHT = 2'd0;
   localparam logic [KIND_W-1:0] KIND_DELTA  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_RUN    = 2'd2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_LAYER_COUNT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INPUT_COUNT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LAYER1      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LAYER2      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LAYER3      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_LAYER4      = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_RATE   = 3'd6;

   // Datapath micro-ops
   localparam int UOP_W = 4;
   localparam logic [UOP_W-1:0] UOP_NONE    = 4'd0;
   localparam logic [UOP_W-1:0] UOP_BS_RD_D = 4'd1;
   localparam logic [UOP_W-1:0] UOP_BS_RD_W = 4'd2;
   localparam logic [UOP_W-1:0] UOP_BS_MUL  = 4'd3;
   localparam logic [UOP_W-1:0] UOP_BS_RND  = 4'd4;
   localparam logic [UOP_W-1:0] UOP_BS_ACC  = 4'd5;
   localparam logic [UOP_W-1:0] UOP_D_RD    = 4'd6;
   localparam logic [UOP_W-1:0] UOP_D_MUL   = 4'd7;
   localparam logic [UOP_W-1:0] UOP_D_SAT   = 4'd8;
   localparam logic [UOP_W-1:0] UOP_R_MUL   = 4'd9;
   localparam logic [UOP_W-1:0] UOP_R_SAT   = 4'd10;
   localparam logic [UOP_W-1:0] UOP_U_RD    = 4'd11;
   localparam logic [UOP_W-1:0] UOP_U_MUL   = 4'd12;
   localparam logic [UOP_W-1:0] UOP_U_RND   = 4'd13;
   localparam logic [UOP_W-1:0] UOP_U_WR    = 4'd14;
   localparam logic [UOP_W-1:0] UOP_EMIT    = 4'd15;

   typedef struct packed {
      logic [LCNT_W-1:0]                  layer_count;
      logic [ICNT_W-1:0]                  input_count;
      logic [REG_LAYERS-1:0][NODE_W-1:0]  nodes;
      logic [RATE_W-1:0]                  rate_q16;
   } cfg_type;

   typedef struct packed {
      logic               accept;
      logic [UOP_W-1:0]   uop;
      logic [NEUR_W-1:0]  row;       // weight row and delta address
      logic [FAN_W-1:0]   w_col;
      logic [VEC_W-1:0]   vaddr;
      logic [NIDX_W-1:0]  node_addr; // back sum and error address
      logic               first;
      logic               last;
      logic               bs_zero;
   } cmd_type;

endpackage

FILE: hw/rtl/mlpbp_ctrl.sv
// Sequencer for loads, reads and the backpropagation pass.
module mlpbp_ctrl import mlpbp_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  cfg_type         cfg,
   input  logic            req_valid,
   output logic            req_stall,
   input  logic [OP_W-1:0] req_op,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output cmd_type         cmd
);

   localparam logic [4:0] S_IDLE  = 5'd0;
   localparam logic [4:0] S_LAYER = 5'd1;
   localparam logic [4:0] S_BS_D  = 5'd2;
   localparam logic [4:0] S_BS_W  = 5'd3;
   localparam logic [4:0] S_BS_M  = 5'd4;
   localparam logic [4:0] S_BS_R  = 5'd5;
   localparam logic [4:0] S_BS_A  = 5'd6;
   localparam logic [4:0] S_D_R   = 5'd7;
   localparam logic [4:0] S_D_M   = 5'd8;
   localparam logic [4:0] S_D_S   = 5'd9;
   localparam logic [4:0] S_R_M   = 5'd10;
   localparam logic [4:0] S_R_S   = 5'd11;
   localparam logic [4:0] S_U_R   = 5'd12;
   localparam logic [4:0] S_U_M   = 5'd13;
   localparam logic [4:0] S_U_N   = 5'd14;
   localparam logic [4:0] S_U_W   = 5'd15;
   localparam logic [4:0] S_NEXT  = 5'd16;
   localparam logic [4:0] S_EMIT  = 5'd17;

   logic [4:0]         state_ff, state_in;
   logic [LAYER_W-1:0] li_ff, li_in;
   logic [NIDX_W-1:0]  k_ff, k_in, l_ff, l_in;
   logic [FAN_W-1:0]   j_ff, j_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic [CNT_W-1:0]   n_g     [MAX_LAYERS];
   logic [NEUR_W-1:0]  base_g  [MAX_LAYERS];
   logic [VEC_W-1:0]   start_g [MAX_LAYERS];
   logic [FANC_W-1:0]  fan_g   [MAX_LAYERS];
   logic [LCNT_W-1:0]  lay;
   logic [ICNT_W-1:0]  ins;

   logic [LAYER_W-1:0] li_last, li_nx;
   logic               last, emit, bs_phase, u_phase;
   logic [CNT_W-1:0]   ncur, nnext;
   logic [NEUR_W-1:0]  bcur, bnext;
   logic [VEC_W-1:0]   st, sp;
   logic [FANC_W-1:0]  fan;
   logic               k_end, kn_end, l_end, j_end;

   // layer geometry from the registers, saturated to the store sizes
   always_comb begin
      lay = (cfg.layer_count > LCNT_W'(MAX_LAYERS)) ? LCNT_W'(MAX_LAYERS) : cfg.layer_count;
      ins = (cfg.input_count > ICNT_W'(MAX_FANIN - 1)) ? ICNT_W'(MAX_FANIN - 1)
                                                       : cfg.input_count;
      for (int i = 0; i < MAX_LAYERS; i++) begin
         n_g[i] = (cfg.nodes[i] > NODE_W'(MAX_NODES)) ? CNT_W'(MAX_NODES)
                                                      : CNT_W'(cfg.nodes[i]);
         if (i == 0) begin
            base_g[i]  = '0;
            start_g[i] = '0;
            fan_g[i]   = FANC_W'(ins) + FANC_W'(1);
         end else begin
            base_g[i]  = base_g[i-1] + NEUR_W'(n_g[i-1]);
            start_g[i] = start_g[i-1] + VEC_W'(fan_g[i-1]);
            fan_g[i]   = FANC_W'(n_g[i-1]) + FANC_W'(1);
         end
      end
   end

   assign li_last = LAYER_W'(lay - LCNT_W'(1));
   assign li_nx   = li_ff + LAYER_W'(1);
   assign last    = (li_ff == li_last);
   assign ncur    = n_g[li_ff];
   assign nnext   = n_g[li_nx];
   assign bcur    = base_g[li_ff];
   assign bnext   = base_g[li_nx];
   assign st      = start_g[li_ff];
   assign fan     = fan_g[li_ff];
   assign sp      = st + VEC_W'(fan);

   assign k_end  = (CNT_W'(k_ff) + CNT_W'(1) == ncur);
   assign kn_end = (CNT_W'(k_ff) + CNT_W'(1) == nnext);
   assign l_end  = (CNT_W'(l_ff) + CNT_W'(1) == ncur);
   assign j_end  = (FANC_W'(j_ff) + FANC_W'(1) == fan);

   assign emit     = (state_ff == S_EMIT) && (!rsp_valid_ff || !rsp_stall);
   assign bs_phase = (state_ff == S_BS_D) || (state_ff == S_BS_W) || (state_ff == S_BS_M) ||
                     (state_ff == S_BS_R) || (state_ff == S_BS_A);
   assign u_phase  = (state_ff == S_U_R) || (state_ff == S_U_M) || (state_ff == S_U_N) ||
                     (state_ff == S_U_W);

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      li_in        = li_ff;
      k_in         = k_ff;
      l_in         = l_ff;
      j_in         = j_ff;
      rsp_valid_in = emit | (rsp_valid_ff & rsp_stall);
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               unique case (req_op)
                  OP_RUN: begin
                     if (lay == '0) begin
                        state_in = S_EMIT;
                     end else begin
                        li_in    = li_last;
                        state_in = S_LAYER;
                     end
                  end
                  OP_READ_W, OP_READ_D: state_in = S_EMIT;
                  default: ;
               endcase
            end
         end
         S_LAYER: begin
            k_in = '0;
            l_in = '0;
            j_in = '0;
            priority if (ncur == '0) state_in = S_NEXT;
            else if (!last && nnext != '0) state_in = S_BS_D;
            else state_in = S_D_R;
         end
         S_BS_D: state_in = S_BS_W;
         S_BS_W: state_in = S_BS_M;
         S_BS_M: state_in = S_BS_R;
         S_BS_R: state_in = S_BS_A;
         S_BS_A: begin
            if (l_end) begin
               l_in = '0;
               if (kn_end) begin
                  k_in     = '0;
                  state_in = S_D_R;
               end else begin
                  k_in     = k_ff + NIDX_W'(1);
                  state_in = S_BS_D;
               end
            end else begin
               l_in     = l_ff + NIDX_W'(1);
               state_in = S_BS_W;
            end
         end
         S_D_R: state_in = S_D_M;
         S_D_M: state_in = S_D_S;
         S_D_S: state_in = S_R_M;
         S_R_M: state_in = S_R_S;
         S_R_S: begin
            j_in     = '0;
            state_in = S_U_R;
         end
         S_U_R: state_in = S_U_M;
         S_U_M: state_in = S_U_N;
         S_U_N: state_in = S_U_W;
         S_U_W: begin
            if (j_end) begin
               j_in = '0;
               if (k_end) begin
                  state_in = S_NEXT;
               end else begin
                  k_in     = k_ff + NIDX_W'(1);
                  state_in = S_D_R;
               end
            end else begin
               j_in     = j_ff + FAN_W'(1);
               state_in = S_U_R;
            end
         end
         S_NEXT: begin
            if (li_ff == '0) begin
               state_in = S_EMIT;
            end else begin
               li_in    = li_ff - LAYER_W'(1);
               state_in = S_LAYER;
            end
         end
         S_EMIT: if (emit) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd           = '0;
      cmd.accept    = (state_ff == S_IDLE) && req_valid;
      cmd.row       = bs_phase ? bnext + NEUR_W'(k_ff) : bcur + NEUR_W'(k_ff);
      cmd.w_col     = bs_phase ? FAN_W'(l_ff) : j_ff;
      cmd.vaddr     = u_phase ? st + VEC_W'(j_ff) : sp + VEC_W'(k_ff);
      cmd.node_addr = bs_phase ? l_ff : k_ff;
      cmd.first     = (k_ff == '0);
      cmd.last      = last;
      cmd.bs_zero   = (nnext == '0);
      unique case (state_ff)
         S_BS_D:  cmd.uop = UOP_BS_RD_D;
         S_BS_W:  cmd.uop = UOP_BS_RD_W;
         S_BS_M:  cmd.uop = UOP_BS_MUL;
         S_BS_R:  cmd.uop = UOP_BS_RND;
         S_BS_A:  cmd.uop = UOP_BS_ACC;
         S_D_R:   cmd.uop = UOP_D_RD;
         S_D_M:   cmd.uop = UOP_D_MUL;
         S_D_S:   cmd.uop = UOP_D_SAT;
         S_R_M:   cmd.uop = UOP_R_MUL;
         S_R_S:   cmd.uop = UOP_R_SAT;
         S_U_R:   cmd.uop = UOP_U_RD;
         S_U_M:   cmd.uop = UOP_U_MUL;
         S_U_N:   cmd.uop = UOP_U_RND;
         S_U_W:   cmd.uop = UOP_U_WR;
         S_EMIT:  cmd.uop = emit ? UOP_EMIT : UOP_NONE;
         default: cmd.uop = UOP_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         li_ff        <= '0;
         k_ff         <= '0;
         l_ff         <= '0;
         j_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         li_ff        <= li_in;
         k_ff         <= k_in;
         l_ff         <= l_in;
         j_ff         <= j_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: hw/rtl/mlpbp_dp.sv
// Datapath: weight, vector, delta and back-sum memories, shared multiplier, rounding.
module mlpbp_dp import mlpbp_pkg::*; (
   input  logic                    clock,
   input  cmd_type                 cmd,
   input  logic [RATE_W-1:0]       rate_q16,
   input  logic [OP_W-1:0]         req_op,
   input  logic [NEUR_FLD_W-1:0]   req_neuron,
   input  logic [POS_W-1:0]        req_position,
   input  logic signed [VAL_W-1:0] req_value,
   output logic [KIND_W-1:0]       rsp_kind,
   output logic signed [VAL_W-1:0] rsp_result_value
);

   function automatic logic signed [TERM_W-1:0] rnd16(input logic signed [PROD_W-1:0] p);
      logic signed [PROD_W-1:0] q;
      q = p + PROD_W'(1 << (FRAC_W - 1));
      return q[PROD_W-1:FRAC_W];
   endfunction

   function automatic logic signed [VAL_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
      logic signed [VAL_W-1:0] r;
      if (v > 64'sd2147483647) r = 32'sh7FFF_FFFF;
      else if (v < -64'sd2147483648) r = 32'sh8000_0000;
      else r = v[VAL_W-1:0];
      return r;
   endfunction

   logic signed [VAL_W-1:0]  ow_mem [1 << WADDR_W];
   logic signed [VAL_W-1:0]  nw_mem [1 << WADDR_W];
   logic signed [VAL_W-1:0]  act_mem [VEC_DEPTH];
   logic signed [VAL_W-1:0]  der_mem [VEC_DEPTH];
   logic signed [VAL_W-1:0]  err_mem [MAX_NODES];
   logic signed [VAL_W-1:0]  dl_mem [NEURONS];
   logic signed [BSUM_W-1:0] bs_mem [MAX_NODES];

   logic signed [VAL_W-1:0]  ow_rd_ff, nw_rd_ff, act_rd_ff, der_rd_ff, err_rd_ff, dl_rd_ff;
   logic signed [BSUM_W-1:0] bs_rd_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [TERM_W-1:0] term_ff, rnd_val;
   logic signed [VAL_W-1:0]  d_ff, step_ff;
   logic [KIND_W-1:0]        kind_ff, rsp_kind_ff;
   logic                     zero_ff;
   logic signed [VAL_W-1:0]  rsp_value_ff;

   logic                     w_ok, vec_ok, err_ok, dl_ok;
   logic [WADDR_W-1:0]       ld_waddr, run_waddr;
   logic signed [VAL_W-1:0]  mul_a, mul_b, d_opnd, d_new, step_new, nw_new;
   logic signed [BSUM_W-1:0] bs_new;
   logic [NEUR_W-1:0]        dl_raddr;
   logic                     is_mul;

   assign w_ok   = (32'(req_neuron) < 32'(NEURONS)) && (32'(req_position) < 32'(MAX_FANIN));
   assign vec_ok = 32'(req_position) < 32'(VEC_DEPTH);
   assign err_ok = 32'(req_position) < 32'(MAX_NODES);
   assign dl_ok  = 32'(req_neuron) < 32'(NEURONS);

   assign ld_waddr  = {NEUR_W'(req_neuron), FAN_W'(req_position)};
   assign run_waddr = {cmd.row, cmd.w_col};
   assign dl_raddr  = (cmd.uop == UOP_BS_RD_D) ? cmd.row : NEUR_W'(req_neuron);

   assign rnd_val  = rnd16(prod_ff);
   assign d_new    = sat32(PROD_W'(rnd_val));
   assign step_new = d_new;
   assign nw_new   = sat32(PROD_W'(ow_rd_ff) + PROD_W'(term_ff));
   assign bs_new   = (cmd.first ? BSUM_W'(0) : bs_rd_ff) + BSUM_W'(term_ff);
   assign d_opnd   = cmd.last ? err_rd_ff
                   : (cmd.bs_zero ? VAL_W'(0) : sat32(PROD_W'(bs_rd_ff)));

   // one multiplier shared by every product of the pass
   always_comb begin
      mul_a  = '0;
      mul_b  = '0;
      is_mul = 1'b1;
      unique case (cmd.uop)
         UOP_BS_MUL: begin mul_a = dl_rd_ff; mul_b = ow_rd_ff; end
         UOP_D_MUL:  begin mul_a = d_opnd;   mul_b = der_rd_ff; end
         UOP_R_MUL:  begin mul_a = $signed(VAL_W'(rate_q16)); mul_b = d_ff; end
         UOP_U_MUL:  begin mul_a = step_ff;  mul_b = act_rd_ff; end
         default:    is_mul = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (is_mul) prod_ff <= PROD_W'(mul_a) * PROD_W'(mul_b);
      if (cmd.uop == UOP_BS_RND || cmd.uop == UOP_U_RND) term_ff <= rnd_val;
      if (cmd.uop == UOP_D_SAT) d_ff <= d_new;
      if (cmd.uop == UOP_R_SAT) step_ff <= step_new;
   end

   // old weights
   always_ff @(posedge clock) begin
      if (cmd.accept && req_op == OP_LOAD_W && w_ok) ow_mem[ld_waddr] <= req_value;
      if (cmd.uop == UOP_BS_RD_W || cmd.uop == UOP_U_RD) ow_rd_ff <= ow_mem[run_waddr];
   end

   // new weights
   always_ff @(posedge clock) begin
      if (cmd.uop == UOP_U_WR) nw_mem[run_waddr] <= nw_new;
      if (cmd.accept && req_op == OP_READ_W) nw_rd_ff <= nw_mem[ld_waddr];
   end

   // activations
   always_ff @(posedge clock) begin
      if (cmd.accept && req_op == OP_LOAD_A && vec_ok)
         act_mem[VEC_W'(req_position)] <= req_value;
      if (cmd.uop == UOP_U_RD) act_rd_ff <= act_mem[cmd.vaddr];
   end

   // derivatives
   always_ff @(posedge clock) begin
      if (cmd.accept && req_op == OP_LOAD_D && vec_ok)
         der_mem[VEC_W'(req_position)] <= req_value;
      if (cmd.uop == UOP_D_RD) der_rd_ff <= der_mem[cmd.vaddr];
   end

   // output errors
   always_ff @(posedge clock) begin
      if (cmd.accept && req_op == OP_LOAD_E && err_ok)
         err_mem[NIDX_W'(req_position)] <= req_value;
      if (cmd.uop == UOP_D_RD) err_rd_ff <= err_mem[cmd.node_addr];
   end

   // deltas
   always_ff @(posedge clock) begin
      if (cmd.uop == UOP_D_SAT) dl_mem[cmd.row] <= d_new;
      if (cmd.uop == UOP_BS_RD_D || (cmd.accept && req_op == OP_READ_D))
         dl_rd_ff <= dl_mem[dl_raddr];
   end

   // back sums, first term of a layer overwrites the stale entry
   always_ff @(posedge clock) begin
      if (cmd.uop == UOP_BS_ACC) bs_mem[cmd.node_addr] <= bs_new;
      if (cmd.uop == UOP_BS_RD_W || cmd.uop == UOP_D_RD) bs_rd_ff <= bs_mem[cmd.node_addr];
   end

   // result beat
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         unique case (req_op)
            OP_READ_W: begin kind_ff <= KIND_WEIGHT; zero_ff <= !w_ok;  end
            OP_READ_D: begin kind_ff <= KIND_DELTA;  zero_ff <= !dl_ok; end
            OP_RUN:    begin kind_ff <= KIND_RUN;    zero_ff <= 1'b1;   end
            default: ;
         endcase
      end
      if (cmd.uop == UOP_EMIT) begin
         rsp_kind_ff  <= kind_ff;
         rsp_value_ff <= zero_ff ? VAL_W'(0)
                       : (kind_ff == KIND_WEIGHT ? nw_rd_ff : dl_rd_ff);
      end
   end

   assign rsp_kind         = rsp_kind_ff;
   assign rsp_result_value = rsp_value_ff;

endmodule

FILE: hw/rtl/mlp_backprop_weight_update.sv
// Top level of the MLP backpropagation weight update block.
//
// Request channel (req_*): one beat per operation. Loads of weights, activations,
// derivatives and output errors are taken one per cycle and give no result.
// A weight or delta read is taken, then its result beat is registered into the
// output register once that register is free; the request side stalls until that
// beat is loaded. A run beat starts one pass from the last layer to the first and
// answers with a run-complete beat (value zero).
// Every product goes through the single 32x32 multiplier and every store has
// one read port.
// Result channel (rsp_*): rsp_valid holds with a stable payload while rsp_stall
// is high; a new result waits in the sequencer until the output register frees.
// Config channel (csr_*): always ready; write only while the block is idle.
// Reset (synchronous, active high) returns the sequencer to idle and restores
// the register defaults; the stores keep no reset value and need no clearing.
module mlp_backprop_weight_update import mlpbp_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [OP_W-1:0]           req_op,
   input  logic [NEUR_FLD_W-1:0]     req_neuron,
   input  logic [POS_W-1:0]          req_position,
   input  logic signed [VAL_W-1:0]   req_value,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [KIND_W-1:0]         rsp_kind,
   output logic signed [VAL_W-1:0]   rsp_result_value,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_data
);

   cfg_type cfg_ff, cfg_in;
   cmd_type cmd;

   assign csr_ready = 1'b1;

   // register file; unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_LAYER_COUNT: cfg_in.layer_count = csr_data[LCNT_W-1:0];
            CSR_INPUT_COUNT: cfg_in.input_count = csr_data[ICNT_W-1:0];
            CSR_LAYER1:      cfg_in.nodes[0]    = csr_data[NODE_W-1:0];
            CSR_LAYER2:      cfg_in.nodes[1]    = csr_data[NODE_W-1:0];
            CSR_LAYER3:      cfg_in.nodes[2]    = csr_data[NODE_W-1:0];
            CSR_LAYER4:      cfg_in.nodes[3]    = csr_data[NODE_W-1:0];
            CSR_STEP_RATE:   cfg_in.rate_q16    = csr_data[RATE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.layer_count <= LCNT_W'(2);
         cfg_ff.input_count <= ICNT_W'(4);
         cfg_ff.nodes       <= {REG_LAYERS{NODE_W'(1)}};
         cfg_ff.rate_q16    <= RATE_W'(6554);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   mlpbp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_op    (req_op),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   mlpbp_dp u_dp (
      .clock            (clock),
      .cmd              (cmd),
      .rate_q16         (cfg_ff.rate_q16),
      .req_op           (req_op),
      .req_neuron       (req_neuron),
      .req_position     (req_position),
      .req_value        (req_value),
      .rsp_kind         (rsp_kind),
      .rsp_result_value (rsp_result_value)
   );

endmodule

FILE: hw/rtl/mlpbp_checker.sv
// Port-level checks for the MLP backpropagation weight update block.
module mlpbp_checker import mlpbp_pkg::*; (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_stall,
   input logic [OP_W-1:0]         req_op,
   input logic                    rsp_valid,
   input logic                    rsp_stall,
   input logic [KIND_W-1:0]       rsp_kind,
   input logic signed [VAL_W-1:0] rsp_result_value
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_result_value))
      else $error("result beat changed while stalled");

   a_run_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_RUN |-> rsp_result_value == '0)
      else $error("run-complete beat carries a value");

   a_load_stream: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_op == OP_LOAD_W || req_op == OP_LOAD_A ||
      req_op == OP_LOAD_D || req_op == OP_LOAD_E) |=> !req_stall)
      else $error("load did not leave the block ready");

   a_busy_after_cmd: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_op == OP_RUN || req_op == OP_READ_W ||
      req_op == OP_READ_D) |=> req_stall)
      else $error("block ready right after a run or read");

endmodule

bind mlp_backprop_weight_update mlpbp_checker u_mlpbp_checker (.*);

FILE: tb/sv/tb_top.sv
// Self-checking testbench for the MLP backpropagation weight update block.
module tb_top;
   import mlpbp_pkg::*;

   // op code 7 has no meaning; the block must ignore it
   localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;
   localparam int WATCHDOG_LIMIT = 1000000;
   localparam int RANDOM_ITEMS   = 1500;

   typedef struct {
      logic [OP_W-1:0]         op;
      logic [NEUR_FLD_W-1:0]   neuron;
      logic [POS_W-1:0]        position;
      logic signed [VAL_W-1:0] value;
   } req_beat_type;

   typedef struct {
      logic [KIND_W-1:0]       kind;
      logic signed [VAL_W-1:0] value;
   } rsp_beat_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [OP_W-1:0]           req_op = '0;
   logic [NEUR_FLD_W-1:0]     req_neuron = '0;
   logic [POS_W-1:0]          req_position = '0;
   logic signed [VAL_W-1:0]   req_value = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [KIND_W-1:0]         rsp_kind;
   logic signed [VAL_W-1:0]   rsp_result_value;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_IDX_W-1:0]      csr_index = '0;
   logic [CSR_DATA_W-1:0]     csr_data = '0;

   mlp_backprop_weight_update dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Network mirror: stores, register copies and layer layout
   // ---------------------------------------------------------------------
   int     old_w [NEURONS*MAX_FANIN];
   int     new_w [NEURONS*MAX_FANIN];
   int     act_vec [VEC_DEPTH];
   int     der_vec [VEC_DEPTH];
   int     out_err [MAX_NODES];
   int     delta_mem [NEURONS];
   longint back_sum [MAX_NODES];

   bit [LCNT_W-1:0] layers_cfg = 3'd2;
   bit [ICNT_W-1:0] inputs_cfg = 7'd4;
   bit [NODE_W-1:0] nodes_cfg [REG_LAYERS] = '{7'd1, 7'd1, 7'd1, 7'd1};
   bit [RATE_W-1:0] rate_cfg = 17'd6554;

   // layout derived from the registers, shared by predictor and stimulus
   int lay_cnt;
   int lay_n [MAX_LAYERS];
   int lay_base [MAX_LAYERS];
   int lay_start [MAX_LAYERS];
   int lay_fan [MAX_LAYERS];

   // entries that a queued run is known to have written
   bit nw_written [NEURONS*MAX_FANIN];
   bit dl_written [NEURONS];

   // entries that a queued load has written
   bit ow_set [NEURONS*MAX_FANIN];
   bit act_set [VEC_DEPTH];
   bit der_set [VEC_DEPTH];
   bit err_set [MAX_NODES];

   req_beat_type pending_beats[$];
   rsp_beat_type expected_rsp[$];

   int  mismatches = 0;
   int  random_items = 0;
   int  quiet_cycles = 0;
   bit  idle_on = 1'b1;
   bit  req_taken = 1'b0;
   bit  csr_taken = 1'b0;
   int  req_gap = 0;
   int  stall_left = 0;
   req_beat_type cur_beat;

   function automatic int sat32(longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return int'(v);
   endfunction

   // round half up, then drop the 16 fraction bits
   function automatic longint rnd16(longint p);
      return (p + 64'sd32768) >>> 16;
   endfunction

   function automatic int vec_at(const ref int arr [VEC_DEPTH], input int idx);
      return (idx < VEC_DEPTH) ? arr[idx] : 0;
   endfunction

   function automatic void build_layout();
      int ins;
      lay_cnt = (layers_cfg > MAX_LAYERS) ? MAX_LAYERS : int'(layers_cfg);
      ins = (inputs_cfg > MAX_FANIN - 1) ? MAX_FANIN - 1 : int'(inputs_cfg);
      for (int li = 0; li < lay_cnt; li++) begin
         lay_n[li] = (nodes_cfg[li] > MAX_NODES) ? MAX_NODES : int'(nodes_cfg[li]);
         if (li == 0) begin
            lay_base[li] = 0;
            lay_start[li] = 0;
            lay_fan[li] = ins + 1;
         end else begin
            lay_base[li] = lay_base[li-1] + lay_n[li-1];
            lay_start[li] = lay_start[li-1] + lay_fan[li-1];
            lay_fan[li] = lay_n[li-1] + 1;
         end
      end
   endfunction

   function automatic void update_row(int row, int d, int st, int fan);
      int     step;
      int     w;
      longint upd;
      step = sat32(rnd16(longint'(rate_cfg) * longint'(d)));
      for (int j = 0; j < fan && j < MAX_FANIN; j++) begin
         w = row * MAX_FANIN + j;
         upd = rnd16(longint'(step) * longint'(vec_at(act_vec, st + j)));
         new_w[w] = sat32(longint'(old_w[w]) + upd);
      end
   endfunction

   // one backward pass, last layer first; deltas use the loaded weights only
   function automatic void backprop_pass();
      int     sp;
      int     d;
      int     nx;
      longint p;
      for (int li = lay_cnt - 1; li >= 0; li--) begin
         sp = lay_start[li] + lay_fan[li];
         if (li == lay_cnt - 1) begin
            for (int k = 0; k < lay_n[li]; k++) begin
               p = longint'(out_err[k]) * longint'(vec_at(der_vec, sp + k));
               d = sat32(rnd16(p));
               delta_mem[lay_base[li] + k] = d;
               update_row(lay_base[li] + k, d, lay_start[li], lay_fan[li]);
            end
         end else begin
            for (int l = 0; l < MAX_NODES; l++) back_sum[l] = 0;
            for (int k = 0; k < lay_n[li+1]; k++) begin
               nx = lay_base[li+1] + k;
               for (int l = 0; l < lay_n[li]; l++)
                  back_sum[l] += rnd16(longint'(delta_mem[nx]) *
                                       longint'(old_w[nx*MAX_FANIN + l]));
            end
            for (int k = 0; k < lay_n[li]; k++) begin
               p = longint'(sat32(back_sum[k])) * longint'(vec_at(der_vec, sp + k));
               d = sat32(rnd16(p));
               delta_mem[lay_base[li] + k] = d;
               update_row(lay_base[li] + k, d, lay_start[li], lay_fan[li]);
            end
         end
      end
   endfunction

   // apply one accepted request beat to the mirror, queue its result if any
   function automatic void apply_beat(req_beat_type b);
      rsp_beat_type r;
      bit wok;
      int waddr;
      wok = (b.position < MAX_FANIN);
      waddr = int'(b.neuron) * MAX_FANIN + int'(b.position);
      case (b.op)
         OP_LOAD_W: if (wok) old_w[waddr] = b.value;
         OP_LOAD_A: act_vec[b.position] = b.value;
         OP_LOAD_D: der_vec[b.position] = b.value;
         OP_LOAD_E: if (b.position < MAX_NODES) out_err[b.position] = b.value;
         OP_RUN: begin
            backprop_pass();
            r.kind = KIND_RUN;
            r.value = 0;
            expected_rsp.push_back(r);
         end
         OP_READ_W: begin
            r.kind = KIND_WEIGHT;
            r.value = wok ? new_w[waddr] : 0;
            expected_rsp.push_back(r);
         end
         OP_READ_D: begin
            r.kind = KIND_DELTA;
            r.value = delta_mem[b.neuron];
            expected_rsp.push_back(r);
         end
         default: ;
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Sampling at the rising edge: result check, request accept, watchdog
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_beat_type e;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result beat: kind %0d value %0d",
                           rsp_kind, rsp_result_value);
            end else begin
               e = expected_rsp.pop_front();
               if (rsp_kind !== e.kind || rsp_result_value !== e.value) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("result mismatch: expected kind %0d value %0d, got kind %0d value %0d",
                              e.kind, e.value, rsp_kind, rsp_result_value);
               end
            end
         end
         req_taken = req_valid && !req_stall;
         if (req_taken) apply_beat(cur_beat);
         csr_taken = csr_valid && csr_ready;
         if ((rsp_valid && !rsp_stall) || req_taken || csr_taken)
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
         end
      end
   end

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      if (!idle_on) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // request driver: new beat only once the current one has been taken
   always @(negedge clock) begin
      if (!reset && (!req_valid || req_taken)) begin
         req_taken = 1'b0;
         if (req_gap > 0) begin
            req_gap <= req_gap - 1;
            req_valid <= 1'b0;
         end else if (pending_beats.size() > 0) begin
            cur_beat = pending_beats.pop_front();
            req_op <= cur_beat.op;
            req_neuron <= cur_beat.neuron;
            req_position <= cur_beat.position;
            req_value <= cur_beat.value;
            req_valid <= 1'b1;
            req_gap <= pick_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result back-pressure
   always @(negedge clock) begin
      if (!reset) begin
         if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_stall <= 1'b1;
         end else if (pick_gap() > 0) begin
            stall_left <= pick_gap();
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   function automatic void push_beat(logic [OP_W-1:0] op, int neuron, int pos, int val,
                                     bit counted);
      req_beat_type b;
      b.op = op;
      b.neuron = neuron[NEUR_FLD_W-1:0];
      b.position = pos[POS_W-1:0];
      b.value = val;
      pending_beats.push_back(b);
      case (b.op)
         OP_LOAD_W: if (b.position < MAX_FANIN)
            ow_set[int'(b.neuron) * MAX_FANIN + int'(b.position)] = 1'b1;
         OP_LOAD_A: act_set[b.position] = 1'b1;
         OP_LOAD_D: der_set[b.position] = 1'b1;
         OP_LOAD_E: if (b.position < MAX_NODES) err_set[b.position] = 1'b1;
         default: ;
      endcase
      if (counted) random_items++;
   endfunction

   function automatic int rand_q16();
      int r;
      r = $urandom_range(0, 99);
      if (r < 5) return 32'sh7fffffff;
      if (r < 10) return 32'sh80000000;
      if (r < 35) return $urandom();
      return int'($urandom_range(0, 262143)) - 131072;
   endfunction

   // queue a run and note which deltas and new weights it leaves defined
   function automatic void push_run(bit counted);
      push_beat(OP_RUN, $urandom_range(0, 255), $urandom_range(0, 511), $urandom(), counted);
      for (int li = 0; li < lay_cnt; li++)
         for (int k = 0; k < lay_n[li]; k++) begin
            dl_written[lay_base[li] + k] = 1'b1;
            for (int j = 0; j < lay_fan[li] && j < MAX_FANIN; j++)
               nw_written[(lay_base[li] + k) * MAX_FANIN + j] = 1'b1;
         end
   endfunction

   function automatic void push_reads(int count);
      int nr;
      int pos;
      bit found;
      for (int i = 0; i < count; i++) begin
         found = 1'b0;
         for (int t = 0; t < 30 && !found; t++) begin
            nr = $urandom_range(0, NEURONS - 1);
            pos = $urandom_range(0, MAX_FANIN - 1);
            if (lay_cnt > 0 && t < 25) begin
               int li;
               li = $urandom_range(0, lay_cnt - 1);
               if (lay_n[li] > 0) begin
                  nr = lay_base[li] + $urandom_range(0, lay_n[li] - 1);
                  pos = $urandom_range(0, lay_fan[li] - 1);
               end
            end
            found = $urandom_range(0, 1) ? nw_written[nr*MAX_FANIN + pos] : dl_written[nr];
            if (found) begin
               if (nw_written[nr*MAX_FANIN + pos] && $urandom_range(0, 1))
                  push_beat(OP_READ_W, nr, pos, $urandom(), 1'b1);
               else if (dl_written[nr])
                  push_beat(OP_READ_D, nr, $urandom_range(0, 511), $urandom(), 1'b1);
               else
                  push_beat(OP_READ_W, nr, pos, $urandom(), 1'b1);
            end
         end
         // weight read past the store answers zero
         if (!found || $urandom_range(0, 9) == 0)
            push_beat(OP_READ_W, $urandom_range(0, 255),
                      $urandom_range(MAX_FANIN, 511), $urandom(), 1'b1);
      end
   endfunction

   // reloads aimed at the entries the configured network uses
   function automatic void push_reloads(int count);
      int li;
      int span;
      span = (lay_cnt > 0) ? lay_start[lay_cnt-1] + lay_fan[lay_cnt-1] + lay_n[lay_cnt-1] : 8;
      for (int i = 0; i < count; i++) begin
         li = (lay_cnt > 0) ? $urandom_range(0, lay_cnt - 1) : 0;
         case ($urandom_range(0, 9))
            0, 1, 2: if (lay_cnt > 0 && lay_n[li] > 0)
               push_beat(OP_LOAD_W, lay_base[li] + $urandom_range(0, lay_n[li] - 1),
                         $urandom_range(0, lay_fan[li] - 1), rand_q16(), 1'b1);
            3, 4: push_beat(OP_LOAD_A, 0, $urandom_range(0, span), rand_q16(), 1'b1);
            5, 6: push_beat(OP_LOAD_D, 0, $urandom_range(0, span), rand_q16(), 1'b1);
            7: push_beat(OP_LOAD_E, 0, $urandom_range(0, 15), rand_q16(), 1'b1);
            // loads with fully random fields, some beyond their store
            8: push_beat($urandom_range(0, 3), $urandom_range(0, 255),
                         $urandom_range(0, 511), $urandom(), 1'b1);
            default: push_beat(OP_UNUSED, $urandom_range(0, 255),
                               $urandom_range(0, 511), $urandom(), 1'b0);
         endcase
      end
   endfunction

   // load every entry the configured pass reads that no load has written yet
   function automatic void fill_layout();
      int row;
      int sp;
      for (int li = 0; li < lay_cnt; li++) begin
         sp = lay_start[li] + lay_fan[li];
         for (int j = 0; j < lay_fan[li]; j++)
            if (!act_set[lay_start[li] + j])
               push_beat(OP_LOAD_A, 0, lay_start[li] + j, rand_q16(), 1'b1);
         for (int k = 0; k < lay_n[li]; k++) begin
            row = lay_base[li] + k;
            if (!der_set[sp + k])
               push_beat(OP_LOAD_D, 0, sp + k, rand_q16(), 1'b1);
            if (li == lay_cnt - 1 && !err_set[k])
               push_beat(OP_LOAD_E, 0, k, rand_q16(), 1'b1);
            for (int j = 0; j < lay_fan[li]; j++)
               if (!ow_set[row * MAX_FANIN + j])
                  push_beat(OP_LOAD_W, row, j, rand_q16(), 1'b1);
         end
      end
   endfunction

   // block the caller until the block has drained and gone quiet
   task automatic wait_drained();
      while (pending_beats.size() > 0 || req_valid || expected_rsp.size() > 0)
         @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, int data);
      csr_index <= idx;
      csr_data <= data[CSR_DATA_W-1:0];
      csr_valid <= 1'b1;
      csr_taken = 1'b0;
      do @(negedge clock); while (!csr_taken);
      case (idx)
         CSR_LAYER_COUNT: layers_cfg = data[LCNT_W-1:0];
         CSR_INPUT_COUNT: inputs_cfg = data[ICNT_W-1:0];
         CSR_LAYER1:      nodes_cfg[0] = data[NODE_W-1:0];
         CSR_LAYER2:      nodes_cfg[1] = data[NODE_W-1:0];
         CSR_LAYER3:      nodes_cfg[2] = data[NODE_W-1:0];
         CSR_LAYER4:      nodes_cfg[3] = data[NODE_W-1:0];
         CSR_STEP_RATE:   rate_cfg = data[RATE_W-1:0];
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic configure(int lc, int ic, int n1, int n2, int n3, int n4, int rate);
      write_reg(CSR_LAYER_COUNT, lc);
      write_reg(CSR_INPUT_COUNT, ic);
      write_reg(CSR_LAYER1, n1);
      write_reg(CSR_LAYER2, n2);
      write_reg(CSR_LAYER3, n3);
      write_reg(CSR_LAYER4, n4);
      write_reg(CSR_STEP_RATE, rate);
      build_layout();
      fill_layout();
   endtask

   function automatic int small_nodes();
      return ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 8);
   endfunction

   initial begin
      build_layout();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part under the reset configuration (2 layers, 4 inputs,
      // one neuron each): saturating error and derivative on the output,
      // extreme weight and activation, ignored loads, unknown op, reads.
      push_beat(OP_LOAD_E, 0, 0, 32'sh7fffffff, 1'b0);
      push_beat(OP_LOAD_D, 0, 7, 32'sh7fffffff, 1'b0);
      push_beat(OP_LOAD_D, 0, 5, 32'sh80000000, 1'b0);
      push_beat(OP_LOAD_W, 1, 0, 32'sh80000000, 1'b0);
      push_beat(OP_LOAD_A, 0, 0, 32'sh7fffffff, 1'b0);
      push_beat(OP_LOAD_A, 0, 511, 32'sh80000000, 1'b0);
      push_beat(OP_LOAD_W, 255, 127, 32'sh7fffffff, 1'b0);
      push_beat(OP_LOAD_W, 3, 300, 32'sh12345678, 1'b0);   // position past the row
      push_beat(OP_LOAD_E, 0, 100, 32'sh0badf00d, 1'b0);   // error index past the store
      push_beat(OP_UNUSED, 255, 511, 32'shffffffff, 1'b0);
      fill_layout();
      push_run(1'b0);
      push_beat(OP_READ_D, 0, 0, 0, 1'b0);
      push_beat(OP_READ_D, 1, 0, 0, 1'b0);
      for (int j = 0; j < 5; j++) push_beat(OP_READ_W, 0, j, 0, 1'b0);
      push_beat(OP_READ_W, 1, 0, 0, 1'b0);
      push_beat(OP_READ_W, 1, 1, 0, 1'b0);
      push_beat(OP_READ_W, 1, 511, 0, 1'b0);
      wait_drained();

      // Empty network: nothing to do but the completion beat.
      configure(0, 0, 0, 0, 0, 0, 0);
      push_run(1'b0);
      push_reads(3);
      wait_drained();

      // Layer count and last node count beyond their limits, top rate.
      configure(7, 3, 1, 1, 2, 127, 65536);
      push_run(1'b0);
      push_reads(10);
      wait_drained();

      // Widest first layer feeding a full output layer, rate field at its top.
      configure(2, 127, 2, 127, 1, 1, 131071);
      push_run(1'b0);
      push_reads(10);
      wait_drained();

      // Smallest real network.
      configure(1, 1, 1, 64, 64, 64, 1);
      push_reloads(4);
      push_run(1'b0);
      push_reads(4);
      wait_drained();

      // Random phases: small networks, reloads, runs, reads and noise.
      while (random_items < RANDOM_ITEMS) begin
         idle_on = ($urandom_range(0, 4) != 0);
         configure(($urandom_range(0, 9) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 4),
                   ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 12),
                   small_nodes(), small_nodes(), small_nodes(), small_nodes(),
                   ($urandom_range(0, 4) == 0) ? $urandom_range(0, 131071)
                                               : $urandom_range(0, 65536));
         repeat ($urandom_range(1, 3)) begin
            push_reloads($urandom_range(5, 30));
            push_run(1'b1);
            push_reads($urandom_range(3, 15));
         end
         wait_drained();
      end

      wait_drained();
      repeat (50) @(negedge clock);
      if (mismatches == 0 && expected_rsp.size() == 0)
         $display("tb_top: PASS");
      else
         $display("tb_top: FAIL");
      $finish;
   end

endmodule
